// ----- src/som_pkg.sv -----
// Package for the station orientation mean block: word types for the input
// and result channels, register index codes and the arctangent constant function.
// No dependencies.
package som_pkg;

  typedef struct packed {
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic        [31:0] reading;
    logic               last;
  } som_in_t;

  typedef struct packed {
    logic [31:0] orientation;
    logic        status;
  } som_out_t;

  localparam logic REG_STATION_X = 1'b0;
  localparam logic REG_STATION_Y = 1'b1;

  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [63:0] atan_step(input int i, input int aw);
    logic [63:0] s;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] t;
    int e;
    s = '0;
    q = '0;
    if (i == 0) return 64'd1 << (aw - 3);
    for (int k = 0; k < 64; k++) begin
      e = i * (2 * k + 1);
      if (e < 62) begin
        t = udiv64(64'd1 << (62 - e), 64'(2 * k + 1));
        if (k % 2 == 1) s = s - t;
        else s = s + t;
      end
    end
    r = s;
    for (int n = 0; n < 64; n++) begin
      if (n < aw - 1) begin
        r = r << 1;
        q = q << 1;
        if (r >= TWO_PI_Q60) begin
          r = r - TWO_PI_Q60;
          q = q | 64'd1;
        end
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

endpackage

// ----- src/som_cell.sv -----
// One CORDIC micro-rotation cell with a fixed shift and arctangent constant.
// Does not depend on som_pkg; chained by the top level.
module som_cell #(
  parameter int VW = 35,
  parameter int ZW = 33,
  parameter int SHIFT = 0,
  parameter logic [63:0] ATAN = 64'd0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 prev_valid,
  input  logic                 prev_vec,
  input  logic signed [VW-1:0] prev_x,
  input  logic signed [VW-1:0] prev_y,
  input  logic        [ZW-1:0] prev_z,
  output logic                 next_valid,
  output logic                 next_vec,
  output logic signed [VW-1:0] next_x,
  output logic signed [VW-1:0] next_y,
  output logic        [ZW-1:0] next_z
);
  logic                 valid_r;
  logic                 vec_r;
  logic signed [VW-1:0] x_r, x_nxt;
  logic signed [VW-1:0] y_r, y_nxt;
  logic        [ZW-1:0] z_r, z_nxt;
  logic signed [VW-1:0] xs, ys;
  logic                 cw;
  logic        [ZW-1:0] a;

  assign a  = ATAN[ZW-1:0];
  assign xs = prev_x >>> SHIFT;
  assign ys = prev_y >>> SHIFT;
  assign cw = prev_vec ? !prev_y[VW-1] : prev_z[ZW-1];

  always_comb begin
    if (cw) begin
      x_nxt = prev_x + ys;
      y_nxt = prev_y - xs;
      z_nxt = prev_z + a;
    end else begin
      x_nxt = prev_x - ys;
      y_nxt = prev_y + xs;
      z_nxt = prev_z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    vec_r <= prev_vec;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    z_r   <= z_nxt;
  end

  assign next_valid = valid_r;
  assign next_vec   = vec_r;
  assign next_x     = x_r;
  assign next_y     = y_r;
  assign next_z     = z_r;
endmodule

// ----- src/station_orientation_mean.sv -----
// Top level of the station orientation mean block: sequencer, sums and cell chain.
// Depends on som_pkg and som_cell.
//
// One reference word enters a chain of CORDIC_STEPS cells, one micro-rotation per
// cell, and its rotated vector is added to the sums. A word marked last then
// starts the vectoring pass through the same chain, which is skipped when the run
// had a zero baseline or both sums are zero. A word with a zero baseline and no
// last mark only sets the zero-baseline flag, and one with a zero baseline and the
// last mark goes straight to the result register. A busy result register holds the
// result back until out_ready frees it. One word is in work at a time; the result
// register lets the next word in while a result waits.
module station_orientation_mean #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 32,
  parameter int ACC_WIDTH = 48,
  parameter int CORDIC_STEPS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  som_pkg::som_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output som_pkg::som_out_t out_data,
  input  logic              cfg_wr_en,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import som_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int AW  = ANGLE_WIDTH;
  localparam int ZW  = AW + 1;
  localparam int PRE = (ACC_WIDTH > 61) ? ACC_WIDTH - 61 : 0;
  localparam int AWV = ACC_WIDTH - PRE;
  localparam int VW  = (CW + 3 > AWV + 3) ? CW + 3 : AWV + 3;
  localparam int SW  = ((VW > ACC_WIDTH) ? VW : ACC_WIDTH) + 1;
  localparam int N   = CORDIC_STEPS;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROT  = 3'd1;
  localparam logic [2:0] S_VGO  = 3'd2;
  localparam logic [2:0] S_VEC  = 3'd3;
  localparam logic [2:0] S_PUT  = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic                       last_r, last_nxt;
  logic                       flag_r, flag_nxt;
  logic signed [ACC_WIDTH-1:0] sc_r, sc_nxt, ss_r, ss_nxt;
  logic [AW-1:0]              res_r, res_nxt;
  logic                       rst_st_r, rst_st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  som_out_t                   out_r, out_nxt;
  logic [CW-1:0]              stx_r, sty_r;

  logic                 vld [0:N];
  logic                 vec [0:N];
  logic signed [VW-1:0] cx  [0:N];
  logic signed [VW-1:0] cy  [0:N];
  logic        [ZW-1:0] cz  [0:N];
  logic [N-1:0]         cell_valid;

  logic [CW+31:0]       wrx, wry, wsx, wsy;
  logic [AW+31:0]       wrd;
  logic [CW-1:0]        ex_ref, ey_ref, ex_st, ey_st;
  logic signed [CW:0]   dx, dy;
  logic signed [VW-1:0] dxv, dyv;
  logic                 zero_base;
  logic [AW-1:0]        phi, phq, rres;
  logic [1:0]           quad;

  logic signed [SW-1:0] ac, as_, bc, bs, tc, ts, hi_s, lo_s;
  logic signed [ACC_WIDTH-1:0] satc, sats;
  logic signed [ACC_WIDTH-1:0] shc, shs;
  logic signed [VW-1:0] vx, vy;
  logic                 vzero;
  logic [AW+31:0]       wres;

  assign wrx = {{32{1'b0}}, in_data.ref_x};
  assign wry = {{32{1'b0}}, in_data.ref_y};
  assign wsx = {{32{1'b0}}, cfg_data};
  assign wsy = {{32{1'b0}}, cfg_data};
  assign wrd = {{32{1'b0}}, in_data.reading};
  assign ex_ref = wrx[CW-1:0];
  assign ey_ref = wry[CW-1:0];
  assign ex_st  = stx_r;
  assign ey_st  = sty_r;
  assign dx = $signed({ex_ref[CW-1], ex_ref}) - $signed({ex_st[CW-1], ex_st});
  assign dy = $signed({ey_ref[CW-1], ey_ref}) - $signed({ey_st[CW-1], ey_st});
  assign dxv = {{(VW-CW-1){dx[CW]}}, dx};
  assign dyv = {{(VW-CW-1){dy[CW]}}, dy};
  assign zero_base = (dx == '0) && (dy == '0);

  assign phi  = '0 - wrd[AW-1:0];
  assign phq  = phi + (AW'(1) << (AW - 3));
  assign quad = phq[AW-1:AW-2];
  assign rres = phi - {quad, {(AW-2){1'b0}}};

  assign hi_s = {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
  assign lo_s = ~hi_s;
  assign ac  = {{(SW-ACC_WIDTH){sc_r[ACC_WIDTH-1]}}, sc_r};
  assign as_ = {{(SW-ACC_WIDTH){ss_r[ACC_WIDTH-1]}}, ss_r};
  assign bc  = {{(SW-VW){cx[N][VW-1]}}, cx[N]};
  assign bs  = {{(SW-VW){cy[N][VW-1]}}, cy[N]};
  assign tc  = ac + bc;
  assign ts  = as_ + bs;

  always_comb begin
    if (tc > hi_s) satc = hi_s[ACC_WIDTH-1:0];
    else if (tc < lo_s) satc = lo_s[ACC_WIDTH-1:0];
    else satc = tc[ACC_WIDTH-1:0];
    if (ts > hi_s) sats = hi_s[ACC_WIDTH-1:0];
    else if (ts < lo_s) sats = lo_s[ACC_WIDTH-1:0];
    else sats = ts[ACC_WIDTH-1:0];
  end

  assign shc = sc_r >>> PRE;
  assign shs = ss_r >>> PRE;
  assign vx  = {{(VW-AWV){shc[AWV-1]}}, shc[AWV-1:0]};
  assign vy  = {{(VW-AWV){shs[AWV-1]}}, shs[AWV-1:0]};
  assign vzero = (vx == '0) && (vy == '0);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    vld[0] = 1'b0;
    vec[0] = 1'b0;
    cx[0]  = dyv;
    cy[0]  = dxv;
    cz[0]  = {rres[AW-1], rres};
    if (state_r == S_IDLE) begin
      vld[0] = in_valid && !zero_base;
      case (quad)
        2'd1: begin
          cx[0] = -dxv;
          cy[0] = dyv;
        end
        2'd2: begin
          cx[0] = -dyv;
          cy[0] = -dxv;
        end
        2'd3: begin
          cx[0] = dxv;
          cy[0] = -dyv;
        end
        default: begin
          cx[0] = dyv;
          cy[0] = dxv;
        end
      endcase
    end else if (state_r == S_VGO) begin
      vld[0] = !flag_r && !vzero;
      vec[0] = 1'b1;
      if (vx[VW-1]) begin
        cx[0] = -vx;
        cy[0] = -vy;
        cz[0] = ZW'(1) << (AW - 1);
      end else begin
        cx[0] = vx;
        cy[0] = vy;
        cz[0] = '0;
      end
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    som_cell #(
      .VW(VW),
      .ZW(ZW),
      .SHIFT(g),
      .ATAN(atan_step(g, AW))
    ) u_cell (
      .clk(clk),
      .rst_n(rst_n),
      .prev_valid(vld[g]),
      .prev_vec(vec[g]),
      .prev_x(cx[g]),
      .prev_y(cy[g]),
      .prev_z(cz[g]),
      .next_valid(vld[g+1]),
      .next_vec(vec[g+1]),
      .next_x(cx[g+1]),
      .next_y(cy[g+1]),
      .next_z(cz[g+1])
    );
    assign cell_valid[g] = vld[g+1];
  end

  assign wres = {{32{1'b0}}, res_r};

  always_comb begin
    state_nxt     = state_r;
    last_nxt      = last_r;
    flag_nxt      = flag_r;
    sc_nxt        = sc_r;
    ss_nxt        = ss_r;
    res_nxt       = res_r;
    rst_st_nxt    = rst_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_data.last;
          if (zero_base) begin
            flag_nxt = 1'b1;
            if (in_data.last) begin
              res_nxt    = '0;
              rst_st_nxt = 1'b1;
              flag_nxt   = 1'b0;
              sc_nxt     = '0;
              ss_nxt     = '0;
              state_nxt  = S_PUT;
            end
          end else begin
            state_nxt = S_ROT;
          end
        end
      end
      S_ROT: begin
        if (vld[N]) begin
          sc_nxt    = satc;
          ss_nxt    = sats;
          state_nxt = last_r ? S_VGO : S_IDLE;
        end
      end
      S_VGO: begin
        res_nxt    = '0;
        rst_st_nxt = flag_r;
        sc_nxt     = '0;
        ss_nxt     = '0;
        flag_nxt   = 1'b0;
        state_nxt  = (flag_r || vzero) ? S_PUT : S_VEC;
      end
      S_VEC: begin
        if (vld[N]) begin
          res_nxt    = cz[N][AW-1:0];
          rst_st_nxt = 1'b0;
          state_nxt  = S_PUT;
        end
      end
      S_PUT: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.orientation = wres[31:0];
          out_nxt.status      = rst_st_r;
          out_valid_nxt       = 1'b1;
          state_nxt           = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flag_r      <= 1'b0;
      sc_r        <= '0;
      ss_r        <= '0;
      out_valid_r <= 1'b0;
      stx_r       <= '0;
      sty_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      flag_r      <= flag_nxt;
      sc_r        <= sc_nxt;
      ss_r        <= ss_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_STATION_X: stx_r <= wsx[CW-1:0];
          REG_STATION_Y: sty_r <= wsy[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r   <= last_nxt;
    res_r    <= res_nxt;
    rst_st_r <= rst_st_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cell_valid))
    else $error("more than one word in the cell chain");

  a_chain_state: assert property (@(posedge clk) disable iff (!rst_n)
    vld[N] |-> (state_r == S_ROT || state_r == S_VEC))
    else $error("chain output with no pass in flight");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status) |-> (out_r.orientation == '0))
    else $error("error result with nonzero orientation");

  a_vec_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (vld[N] && state_r == S_VEC) |-> vec[N])
    else $error("rotation word seen during vectoring");
`endif
endmodule
